// ===== sv/cnaw_pkg.sv =====
// Shared types, constants and character tables of the cpio newc archive walker.
package cnaw_pkg;

  localparam int COUNT_WIDTH = 16;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Header byte positions.
  localparam logic [6:0] HDR_MAGIC_LEN  = 7'd6;
  localparam logic [6:0] HDR_FSIZE_HEAD = 7'd54;
  localparam logic [6:0] HDR_FSIZE_TAIL = 7'd61;
  localparam logic [6:0] HDR_NSIZE_HEAD = 7'd94;
  localparam logic [6:0] HDR_NSIZE_TAIL = 7'd101;
  localparam logic [6:0] HDR_LAST       = 7'd109;

  // Trailer name index: ten characters and a terminating NUL.
  localparam logic [3:0] TRAILER_LAST = 4'd10;
  localparam logic [3:0] NAME_IDX_SAT = 4'd11;

  localparam logic [2:0] KIND_ENTRY_INFO  = 3'd0;
  localparam logic [2:0] KIND_NAME_BYTE   = 3'd1;
  localparam logic [2:0] KIND_DATA_BYTE   = 3'd2;
  localparam logic [2:0] KIND_ARCHIVE_END = 3'd3;
  localparam logic [2:0] KIND_BAD_MAGIC   = 3'd4;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_NAME,
    PH_NAME_PAD,
    PH_DATA,
    PH_DATA_PAD,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] archive_byte;
    logic       archive_start;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  byte_value;
    logic [31:0] file_size;
    logic [31:0] name_size;
    logic [15:0] entry_count;
    logic [31:0] largest_size;
  } out_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [7:0] magic_char(input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = 8'h30;  // '0'
      3'd1:    c = 8'h37;  // '7'
      3'd2:    c = 8'h30;
      3'd3:    c = 8'h37;
      3'd4:    c = 8'h30;
      3'd5:    c = 8'h31;  // '1'
      default: c = 8'h30;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] trailer_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = 8'h54;  // 'T'
      4'd1:    c = 8'h52;  // 'R'
      4'd2:    c = 8'h41;  // 'A'
      4'd3:    c = 8'h49;  // 'I'
      4'd4:    c = 8'h4C;  // 'L'
      4'd5:    c = 8'h45;  // 'E'
      4'd6:    c = 8'h52;  // 'R'
      4'd7:    c = 8'h21;  // '!'
      4'd8:    c = 8'h21;
      4'd9:    c = 8'h21;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Returns {valid, digit} for an ASCII hex character of either case.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end else begin
      r = 5'b0;
    end
    return r;
  endfunction

endpackage

// ===== sv/cnaw_walker.sv =====
// Front part: per-byte header, name and data walk that classifies each byte.
module cnaw_walker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                emit_payload,
  input  logic                accept,
  input  cnaw_pkg::in_item_t  in_item,
  output logic                res_valid,
  output cnaw_pkg::out_item_t res_item
);
  import cnaw_pkg::*;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] left;
    logic        restart;
  } settle_t;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  phase_t                 phase_r, phase_nxt;
  logic [6:0]             header_pos_r, header_pos_nxt;
  logic [31:0]            hex_accum_r, hex_accum_nxt;
  logic [31:0]            file_size_r, file_size_nxt;
  logic [31:0]            name_size_r, name_size_nxt;
  logic [31:0]            bytes_left_r, bytes_left_nxt;
  logic [1:0]             offset_r, offset_nxt;
  logic                   trailer_match_r, trailer_match_nxt;
  logic [3:0]             name_idx_r, name_idx_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic [31:0]            max_r, max_nxt;

  // Values as seen after an archive start has been applied.
  phase_t                 phase_s;
  logic [6:0]             pos_s;
  logic [1:0]             offset_s;
  logic [31:0]            hex_s;
  logic [COUNT_WIDTH-1:0] count_s;
  logic [31:0]            max_s;

  logic [7:0]             b;
  logic                   start;
  logic                   active;
  logic [1:0]             offset_inc;
  logic                   magic_bad, in_hex, hex_bad, hdr_bad, hdr_end, hex_first;
  logic [4:0]             hex_dec;
  logic [31:0]            hex_new;
  logic [31:0]            left_dec;
  logic                   name_last, match_new, is_trailer;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic [31:0]            max_new;

  function automatic settle_t settle(input phase_t ph, input logic [31:0] left,
                                     input logic [1:0] off, input logic [31:0] fsize);
    settle_t s;
    s.phase   = ph;
    s.left    = left;
    s.restart = 1'b0;
    if (s.phase == PH_NAME && s.left == 32'd0) s.phase = PH_NAME_PAD;
    if (s.phase == PH_NAME_PAD && off == 2'd0) begin
      s.phase = PH_DATA;
      s.left  = fsize;
    end
    if (s.phase == PH_DATA && s.left == 32'd0) s.phase = PH_DATA_PAD;
    if (s.phase == PH_DATA_PAD && off == 2'd0) begin
      s.phase   = PH_HEADER;
      s.restart = 1'b1;
    end
    return s;
  endfunction

  assign b        = in_item.archive_byte;
  assign start    = in_item.archive_start;
  assign phase_s  = start ? PH_HEADER : phase_r;
  assign pos_s    = start ? 7'd0 : header_pos_r;
  assign offset_s = start ? 2'd0 : offset_r;
  assign hex_s    = start ? 32'd0 : hex_accum_r;
  assign count_s  = start ? '0 : count_r;
  assign max_s    = start ? 32'd0 : max_r;

  assign active     = (phase_s != PH_IDLE) && (phase_s != PH_DONE);
  assign offset_inc = offset_s + 2'd1;

  assign magic_bad = (pos_s < HDR_MAGIC_LEN) && (b != magic_char(pos_s[2:0]));
  assign in_hex    = (pos_s >= HDR_FSIZE_HEAD && pos_s <= HDR_FSIZE_TAIL) ||
                     (pos_s >= HDR_NSIZE_HEAD && pos_s <= HDR_NSIZE_TAIL);
  assign hex_dec   = hex_digit(b);
  assign hex_bad   = in_hex && !hex_dec[4];
  assign hdr_bad   = magic_bad || hex_bad;
  assign hdr_end   = pos_s >= HDR_LAST;
  assign hex_first = (pos_s == HDR_FSIZE_HEAD) || (pos_s == HDR_NSIZE_HEAD);
  assign hex_new   = hex_first ? {28'd0, hex_dec[3:0]} : {hex_s[27:0], hex_dec[3:0]};

  assign left_dec   = bytes_left_r - 32'd1;
  assign name_last  = bytes_left_r == 32'd1;
  assign match_new  = trailer_match_r &&
                      ((name_idx_r > TRAILER_LAST) || (b == trailer_char(name_idx_r)));
  assign is_trailer = match_new && (name_idx_r >= TRAILER_LAST);

  assign count_inc = (count_s != COUNT_MAX) ? count_s + 1'b1 : count_s;
  assign max_new   = (file_size_r > max_s) ? file_size_r : max_s;

  // Next state.
  always_comb begin
    settle_t st;
    st                = '{phase: phase_s, left: bytes_left_r, restart: 1'b0};
    phase_nxt         = phase_s;
    header_pos_nxt    = pos_s;
    hex_accum_nxt     = hex_s;
    file_size_nxt     = file_size_r;
    name_size_nxt     = name_size_r;
    bytes_left_nxt    = bytes_left_r;
    offset_nxt        = active ? offset_inc : offset_s;
    trailer_match_nxt = trailer_match_r;
    name_idx_nxt      = name_idx_r;
    count_nxt         = count_s;
    max_nxt           = max_s;
    unique case (phase_s)
      PH_HEADER: begin
        if (hdr_bad) begin
          phase_nxt = PH_IDLE;
        end else begin
          if (in_hex) hex_accum_nxt = hex_new;
          if (pos_s == HDR_FSIZE_TAIL) file_size_nxt = hex_new;
          if (pos_s == HDR_NSIZE_TAIL) name_size_nxt = hex_new;
          if (hdr_end) begin
            trailer_match_nxt = 1'b1;
            name_idx_nxt      = 4'd0;
            if (name_size_r == 32'd0) begin
              count_nxt = count_inc;
              max_nxt   = max_new;
            end
            st             = settle(PH_NAME, name_size_r, offset_inc, file_size_r);
            phase_nxt      = st.phase;
            bytes_left_nxt = st.left;
            if (st.restart) header_pos_nxt = 7'd0;
          end else begin
            header_pos_nxt = pos_s + 7'd1;
          end
        end
      end
      PH_NAME: begin
        trailer_match_nxt = match_new;
        name_idx_nxt      = (name_idx_r == NAME_IDX_SAT) ? name_idx_r : name_idx_r + 4'd1;
        if (name_last && is_trailer) begin
          phase_nxt      = PH_DONE;
          bytes_left_nxt = left_dec;
        end else begin
          if (name_last) begin
            count_nxt = count_inc;
            max_nxt   = max_new;
          end
          st             = settle(PH_NAME, left_dec, offset_inc, file_size_r);
          phase_nxt      = st.phase;
          bytes_left_nxt = st.left;
          if (st.restart) header_pos_nxt = 7'd0;
        end
      end
      PH_DATA: begin
        st             = settle(PH_DATA, left_dec, offset_inc, file_size_r);
        phase_nxt      = st.phase;
        bytes_left_nxt = st.left;
        if (st.restart) header_pos_nxt = 7'd0;
      end
      PH_NAME_PAD, PH_DATA_PAD: begin
        st             = settle(phase_s, bytes_left_r, offset_inc, file_size_r);
        phase_nxt      = st.phase;
        bytes_left_nxt = st.left;
        if (st.restart) header_pos_nxt = 7'd0;
      end
      default: begin
      end
    endcase
  end

  // Result of the accepted byte.
  always_comb begin
    res_valid = 1'b0;
    res_item  = '0;
    if (accept) begin
      unique case (phase_s)
        PH_HEADER: begin
          if (hdr_bad) begin
            res_valid     = 1'b1;
            res_item.kind = KIND_BAD_MAGIC;
          end else if (hdr_end && name_size_r == 32'd0) begin
            res_valid          = 1'b1;
            res_item.kind      = KIND_ENTRY_INFO;
            res_item.file_size = file_size_r;
            res_item.name_size = name_size_r;
          end
        end
        PH_NAME: begin
          if (name_last && is_trailer) begin
            res_valid             = 1'b1;
            res_item.kind         = KIND_ARCHIVE_END;
            res_item.entry_count  = 16'(count_s);
            res_item.largest_size = max_s;
          end else if (name_last) begin
            res_valid          = 1'b1;
            res_item.kind      = KIND_ENTRY_INFO;
            res_item.file_size = file_size_r;
            res_item.name_size = name_size_r;
          end else if (emit_payload) begin
            res_valid           = 1'b1;
            res_item.kind       = KIND_NAME_BYTE;
            res_item.byte_value = b;
          end
        end
        PH_DATA: begin
          if (emit_payload) begin
            res_valid           = 1'b1;
            res_item.kind       = KIND_DATA_BYTE;
            res_item.byte_value = b;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      header_pos_r    <= 7'd0;
      hex_accum_r     <= 32'd0;
      file_size_r     <= 32'd0;
      name_size_r     <= 32'd0;
      bytes_left_r    <= 32'd0;
      offset_r        <= 2'd0;
      trailer_match_r <= 1'b1;
      name_idx_r      <= 4'd0;
      count_r         <= '0;
      max_r           <= 32'd0;
    end else if (accept) begin
      phase_r         <= phase_nxt;
      header_pos_r    <= header_pos_nxt;
      hex_accum_r     <= hex_accum_nxt;
      file_size_r     <= file_size_nxt;
      name_size_r     <= name_size_nxt;
      bytes_left_r    <= bytes_left_nxt;
      offset_r        <= offset_nxt;
      trailer_match_r <= trailer_match_nxt;
      name_idx_r      <= name_idx_nxt;
      count_r         <= count_nxt;
      max_r           <= max_nxt;
    end
  end

endmodule

// ===== sv/cnaw_queue.sv =====
// Short result queue that parts the walker from the output stage.
module cnaw_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  cnaw_pkg::out_item_t  push_data,
  input  logic                 pop,
  output cnaw_pkg::out_item_t  pop_data,
  output cnaw_pkg::q_status_t  status
);
  import cnaw_pkg::*;

  localparam logic [QUEUE_PTR_W-1:0] PTR_LAST = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [QUEUE_CNT_W-1:0] CNT_FULL = QUEUE_CNT_W'(QUEUE_DEPTH);

  out_item_t              slot_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0] count_r, count_nxt;

  assign wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  assign status.full  = count_r == CNT_FULL;
  assign status.empty = count_r == '0;
  assign pop_data     = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_nxt;
      if (pop) rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL) else $error("queue count beyond depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |-> (count_r < CNT_FULL)) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0)) else $error("pop from empty queue");
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not follow a lone push");
`endif

endmodule

// ===== sv/cnaw_out_stage.sv =====
// Back part: output register that takes results from the queue and hands them out.
module cnaw_out_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cnaw_pkg::q_status_t  q_status,
  input  cnaw_pkg::out_item_t  q_data,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cnaw_pkg::out_item_t  out_data
);
  import cnaw_pkg::*;

  logic      valid_r;
  out_item_t data_r;

  assign pop       = !q_status.empty && (!valid_r || !out_stall);
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!valid_r || !out_stall) begin
      valid_r <= !q_status.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) data_r <= q_data;
  end

`ifndef SYNTHESIS
  a_drain_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_stall && q_status.empty) |=> !valid_r)
    else $error("output stayed valid with nothing left to send");
`endif

endmodule

// ===== sv/cpio_newc_archive_walker_top.sv =====
// Top level of the cpio newc archive walker: walker, result queue and output stage.
//
// The block walks a cpio newc archive that arrives one byte per transfer and
// accepts a byte in every clock cycle, one byte per cycle sustained, as long
// as the result side keeps up. Each accepted byte gives at most one result:
// entry info on the final name byte (header byte if the name is empty), name
// and data bytes when emit_payload is set, an archive end report on the trailer
// entry, or a bad magic report. Each result is written into a two-entry queue
// as its byte is accepted and moves on into the output register once that
// register is empty or out_stall is low. in_stall is high exactly while that
// queue is full, so it rises when out_stall holds the output register while
// results keep coming. The per-byte walk itself (header position, hex decode,
// byte counters, pad skipping) is combinational and registered on acceptance.
// The emit_payload register resets to 1 and may only be written while no
// byte is in flight.
module cpio_newc_archive_walker_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cnaw_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cnaw_pkg::out_item_t out_data,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data
);
  import cnaw_pkg::*;

  logic      emit_payload_r;
  logic      accept;
  logic      res_valid;
  out_item_t res_item;
  logic      pop;
  out_item_t q_data;
  q_status_t q_status;

  // The single configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_payload_r <= 1'b1;
    end else if (cfg_wr_en) begin
      emit_payload_r <= cfg_wr_data;
    end
  end

  // A byte is taken whenever the queue has room; a byte that gives no result
  // still advances the walk.
  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;

  cnaw_walker u_walker (
    .clk          (clk),
    .rst_n        (rst_n),
    .emit_payload (emit_payload_r),
    .accept       (accept),
    .in_item      (in_data),
    .res_valid    (res_valid),
    .res_item     (res_item)
  );

  cnaw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res_item),
    .pop       (pop),
    .pop_data  (q_data),
    .status    (q_status)
  );

  cnaw_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
